[src/eds_pkg.sv]
package eds_pkg;

	localparam int TS_W     = 32;
	localparam int ZONE_W   = 17;
	localparam int SUM_W    = 33;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int DOY_W    = 9;

	localparam logic signed [ZONE_W-1:0] ZONE_RESET = 17'sd19800;

	// 86400 = 2^7 * 675
	localparam int DAY_SHIFT   = 7;
	localparam int DAY_ODD     = 675;
	localparam int DAYS_W      = 16;
	localparam int SOD_W       = 17;
	localparam int DAYS_CYCLE  = 1461;
	localparam int CYCLE_W     = 6;
	localparam int DIC_W       = 11;
	localparam int SECS_HOUR   = 3600;
	localparam int SOH_W       = 12;
	localparam int SECS_MINUTE = 60;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
	// day offsets of the years in a four-year cycle starting 1970; 1972 is leap
	localparam logic [DIC_W-1:0] YEAR1_START = 11'd365;
	localparam logic [DIC_W-1:0] YEAR2_START = 11'd730;
	localparam logic [DIC_W-1:0] YEAR3_START = 11'd1096;
	localparam logic [1:0]       LEAP_INDEX  = 2'd2;

	localparam logic [MONTH_W-1:0] JAN = 4'd1;
	localparam logic [MONTH_W-1:0] DEC = 4'd12;

	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DOY_W-1:0] base;
		base = '0;
		unique case (m)
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = '0;
		endcase
		if (m > 4'd2 && leap) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

[src/eds_divc.sv]
// constant divisor: reciprocal estimate, then one correction step
module eds_divc #(
	parameter int W  = 16,
	parameter int D  = 3,
	parameter int QW = 16,
	parameter int RW = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  x,
	output logic [QW-1:0] q,
	output logic [RW-1:0] r
);

	localparam logic [W-1:0] MV = W'((64'd1 << W) / D);
	localparam logic [W-1:0] DV = W'(D);

	logic [2*W-1:0] prod;
	logic [W-1:0]   qe_s1;
	logic [W-1:0]   x_s1;
	logic [W-1:0]   qd;
	logic [W-1:0]   r0;
	logic           ge;

	assign prod = {{W{1'b0}}, x} * {{W{1'b0}}, MV};

	always_ff @(posedge clk) begin
		if (en) begin
			qe_s1 <= prod[2*W-1:W];
			x_s1  <= x;
		end
	end

	// estimate is low by at most one
	assign qd = qe_s1 * DV;
	assign r0 = x_s1 - qd;
	assign ge = (r0 >= DV);

	always_ff @(posedge clk) begin
		if (en) begin
			q <= QW'(qe_s1 + W'(ge));
			r <= RW'(ge ? r0 - DV : r0);
		end
	end

endmodule

[src/eds_date.sv]
// day within four-year cycle -> year, month, day of month
module eds_date (
	input  logic                           clk,
	input  logic                           en,
	input  logic [eds_pkg::CYCLE_W-1:0]    cyc,
	input  logic [eds_pkg::DIC_W-1:0]      dic,
	output logic [eds_pkg::YEAR_W-1:0]     year,
	output logic [eds_pkg::MONTH_W-1:0]    month,
	output logic [eds_pkg::DAY_W-1:0]      day_of_month
);

	logic [1:0]                    yi;
	logic [eds_pkg::DIC_W-1:0]     ystart;
	logic [eds_pkg::YEAR_W-1:0]    year_s1;
	logic [eds_pkg::DOY_W-1:0]     doy_s1;
	logic                          leap_s1;
	logic [eds_pkg::MONTH_W-1:0]   mon;
	logic [eds_pkg::DOY_W-1:0]     mstart;

	always_comb begin
		priority if (dic >= eds_pkg::YEAR3_START) begin
			yi     = 2'd3;
			ystart = eds_pkg::YEAR3_START;
		end else if (dic >= eds_pkg::YEAR2_START) begin
			yi     = 2'd2;
			ystart = eds_pkg::YEAR2_START;
		end else if (dic >= eds_pkg::YEAR1_START) begin
			yi     = 2'd1;
			ystart = eds_pkg::YEAR1_START;
		end else begin
			yi     = 2'd0;
			ystart = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s1 <= eds_pkg::EPOCH_YEAR + eds_pkg::YEAR_W'({cyc, 2'b00})
				+ eds_pkg::YEAR_W'(yi);
			doy_s1  <= eds_pkg::DOY_W'(dic - ystart);
			leap_s1 <= (yi == eds_pkg::LEAP_INDEX);
		end
	end

	always_comb begin
		mon = eds_pkg::JAN;
		for (int m = 2; m <= 12; m++) begin
			if (doy_s1 >= eds_pkg::month_start(eds_pkg::MONTH_W'(m), leap_s1)) begin
				mon = eds_pkg::MONTH_W'(m);
			end
		end
		mstart = eds_pkg::month_start(mon, leap_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year         <= year_s1;
			month        <= mon;
			day_of_month <= eds_pkg::DAY_W'(doy_s1 - mstart + 9'd1);
		end
	end

endmodule

[src/epoch_seconds_to_calendar.sv]
// Pipeline: 7 register stages; an accepted request is offered as a result from the
// last stage register.
// Throughput: one request per cycle; stages advance together and hold while
// the output register is full and not taken.
// Reset: arst_n clears all stage valid bits and loads the zone offset with
// 19800 s; data registers are not reset.
module epoch_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] epoch_seconds
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // year[11:0], month[15:12], day_of_month[20:16],
	                                   // hour[25:21], minute[31:26]
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata      // zone_offset_seconds, signed
);

	logic signed [eds_pkg::ZONE_W-1:0] zone_q;
	logic                              en;
	logic                              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [eds_pkg::SUM_W:0]    sum;
	logic [eds_pkg::SUM_W-1:0]         t_s1;
	logic [eds_pkg::DAY_SHIFT-1:0]     lo_s2, lo_s3;
	logic [eds_pkg::DAYS_W-1:0]        days_s3;
	logic [9:0]                        rday_s3;
	logic [eds_pkg::SOD_W-1:0]         sod;
	logic [eds_pkg::CYCLE_W-1:0]       cyc_s5;
	logic [eds_pkg::DIC_W-1:0]         dic_s5;
	logic [eds_pkg::HOUR_W-1:0]        hour_s5, hour_s6, hour_s7;
	logic [eds_pkg::SOH_W-1:0]         soh_s5;
	logic [eds_pkg::MINUTE_W-1:0]      minute_s7;
	logic [eds_pkg::MINUTE_W-1:0]      second_s7;
	logic [eds_pkg::YEAR_W-1:0]        year_s7;
	logic [eds_pkg::MONTH_W-1:0]       month_s7;
	logic [eds_pkg::DAY_W-1:0]         day_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= eds_pkg::ZONE_RESET;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	assign en            = !v_s7 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// offset add, negative sum clamps to zero
	assign sum = $signed({2'b00, s_axis_tdata})
		+ $signed({{(eds_pkg::SUM_W+1-eds_pkg::ZONE_W){zone_q[eds_pkg::ZONE_W-1]}}, zone_q});

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= sum[eds_pkg::SUM_W] ? '0 : sum[eds_pkg::SUM_W-1:0];
		end
	end

	eds_divc #(
		.W (eds_pkg::SUM_W - eds_pkg::DAY_SHIFT),
		.D (eds_pkg::DAY_ODD),
		.QW(eds_pkg::DAYS_W),
		.RW(10)
	) u_days (
		.clk(clk),
		.en (en),
		.x  (t_s1[eds_pkg::SUM_W-1:eds_pkg::DAY_SHIFT]),
		.q  (days_s3),
		.r  (rday_s3)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2   <= t_s1[eds_pkg::DAY_SHIFT-1:0];
			lo_s3   <= lo_s2;
			hour_s6 <= hour_s5;
			hour_s7 <= hour_s6;
		end
	end

	assign sod = {rday_s3, lo_s3};

	eds_divc #(
		.W (eds_pkg::DAYS_W),
		.D (eds_pkg::DAYS_CYCLE),
		.QW(eds_pkg::CYCLE_W),
		.RW(eds_pkg::DIC_W)
	) u_cycle (
		.clk(clk),
		.en (en),
		.x  (days_s3),
		.q  (cyc_s5),
		.r  (dic_s5)
	);

	eds_divc #(
		.W (eds_pkg::SOD_W),
		.D (eds_pkg::SECS_HOUR),
		.QW(eds_pkg::HOUR_W),
		.RW(eds_pkg::SOH_W)
	) u_hour (
		.clk(clk),
		.en (en),
		.x  (sod),
		.q  (hour_s5),
		.r  (soh_s5)
	);

	eds_divc #(
		.W (eds_pkg::SOH_W),
		.D (eds_pkg::SECS_MINUTE),
		.QW(eds_pkg::MINUTE_W),
		.RW(eds_pkg::MINUTE_W)
	) u_minute (
		.clk(clk),
		.en (en),
		.x  (soh_s5),
		.q  (minute_s7),
		.r  (second_s7)
	);

	eds_date u_date (
		.clk         (clk),
		.en          (en),
		.cyc         (cyc_s5),
		.dic         (dic_s5),
		.year        (year_s7),
		.month       (month_s7),
		.day_of_month(day_s7)
	);

	assign m_axis_tdata = {minute_s7, hour_s7, day_s7, month_s7, year_s7};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted request did not enter stage 1");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (month_s7 >= eds_pkg::JAN && month_s7 <= eds_pkg::DEC
			&& day_s7 != 5'd0 && year_s7 >= eds_pkg::EPOCH_YEAR && year_s7 <= 12'd2106))
		else $error("date out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (hour_s7 <= 5'd23 && minute_s7 <= 6'd59 && second_s7 <= 6'd59))
		else $error("time of day out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && !m_axis_tready) |=> (v_s7 && $stable(v_s6) && $stable(v_s1)))
		else $error("pipeline moved during stall");

endmodule

[bench/epoch_seconds_to_calendar_tb.sv]
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

	localparam int     PIPE_LATENCY  = 7;
	localparam int     STALL_LIMIT   = 3000;
	localparam int     REPORT_LIMIT  = 10;
	localparam longint SEC_MINUTE    = 60;
	localparam longint SEC_HOUR      = 3600;
	localparam longint SEC_DAY       = 86400;
	localparam longint SEC_YEAR      = 31536000;
	localparam longint SEC_LEAP_YEAR = 31622400;
	localparam longint SEC_MON_31    = 2678400;
	localparam longint SEC_MON_30    = 2592000;
	localparam longint SEC_FEB       = 2419200;
	localparam longint SEC_FEB_LEAP  = 2505600;
	localparam longint TS_MAX        = 64'h0000_0000_FFFF_FFFF;
	localparam int     ZONE_DEFAULT  = 19800;
	localparam int     ZONE_WEST     = -43200;
	localparam int     ZONE_EAST     = 50400;
	localparam int     ZONE_MIN_RAW  = -65536;
	localparam int     ZONE_MAX_RAW  = 65535;

	typedef struct packed {
		logic [eds_pkg::MINUTE_W-1:0] minute;
		logic [eds_pkg::HOUR_W-1:0]   hour;
		logic [eds_pkg::DAY_W-1:0]    day_of_month;
		logic [eds_pkg::MONTH_W-1:0]  month;
		logic [eds_pkg::YEAR_W-1:0]   year;
	} calendar_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [eds_pkg::TS_W-1:0]    s_axis_tdata = '0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [31:0]                 m_axis_tdata;
	logic                        cfg_we = 1'b0;
	logic [eds_pkg::ZONE_W-1:0]  cfg_wdata = '0;

	logic signed [eds_pkg::ZONE_W-1:0] zone_now = eds_pkg::ZONE_RESET;
	calendar_t expected_dates[$];
	int fail_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	epoch_seconds_to_calendar dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic longint month_secs(int unsigned yr, int unsigned mo);
		case (mo)
			2:           return (yr % 4 == 0) ? SEC_FEB_LEAP : SEC_FEB;
			4, 6, 9, 11: return SEC_MON_30;
			default:     return SEC_MON_31;
		endcase
	endfunction

	function automatic longint month_begin(int unsigned yr, int unsigned mo);
		longint t;
		t = 0;
		for (int unsigned y = 1970; y < yr; y++) begin
			t += (y % 4 == 0) ? SEC_LEAP_YEAR : SEC_YEAR;
		end
		for (int unsigned m = 1; m < mo; m++) begin
			t += month_secs(yr, m);
		end
		return t;
	endfunction

	function automatic calendar_t to_calendar(logic [31:0] secs,
			logic signed [eds_pkg::ZONE_W-1:0] zone);
		longint      t;
		longint      z;
		longint      len;
		int unsigned yr;
		int unsigned mo;
		calendar_t   c;
		t = secs;
		z = zone;
		t = t + z;
		if (t < 0) begin
			t = 0;
		end
		yr = 1970;
		mo = 1;
		forever begin
			len = (yr % 4 == 0) ? SEC_LEAP_YEAR : SEC_YEAR;
			if (t < len) break;
			t -= len;
			yr++;
		end
		while (mo < 12) begin
			len = month_secs(yr, mo);
			if (t < len) break;
			t -= len;
			mo++;
		end
		c.year         = yr[eds_pkg::YEAR_W-1:0];
		c.month        = mo[eds_pkg::MONTH_W-1:0];
		c.day_of_month = 5'(t / SEC_DAY + 1);
		t = t % SEC_DAY;
		c.hour         = 5'(t / SEC_HOUR);
		t = t % SEC_HOUR;
		c.minute       = 6'(t / SEC_MINUTE);
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic send_request(logic [31:0] secs);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= secs;
		do @(posedge clk); while (!s_axis_tready);
		expected_dates.push_back(to_calendar(secs, zone_now));
	endtask

	task automatic send_clamped(longint v);
		if (v < 0) v = 0;
		if (v > TS_MAX) v = TS_MAX;
		send_request(v[31:0]);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 3) @(posedge clk);
	endtask

	task automatic set_zone(logic [eds_pkg::ZONE_W-1:0] z);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= z;
		@(posedge clk);
		cfg_we    <= 1'b0;
		zone_now   = z;
		@(posedge clk);
	endtask

	task automatic check_result(calendar_t got);
		calendar_t want;
		if (expected_dates.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: unexpected result %0d-%0d-%0d %0d:%0d", $realtime,
					got.year, got.month, got.day_of_month, got.hour, got.minute);
			return;
		end
		want = expected_dates.pop_front();
		if (got.year != want.year || got.month != want.month ||
				got.day_of_month != want.day_of_month || got.hour != want.hour ||
				got.minute != want.minute) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: mismatch exp %0d-%0d-%0d %0d:%0d got %0d-%0d-%0d %0d:%0d",
					$realtime, want.year, want.month, want.day_of_month, want.hour,
					want.minute, got.year, got.month, got.day_of_month, got.hour,
					got.minute);
		end
	endtask

	// result sink with random backpressure
	initial begin : result_sink
		int  hold;
		int  r;
		bit  level;
		hold  = 0;
		level = 1'b1;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) check_result(calendar_t'(m_axis_tdata));
			if (hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					level = 1'b1;
					hold  = $urandom_range(20, 100);
				end else if (r < 65) begin
					level = 1'b1;
					hold  = $urandom_range(1, 4);
				end else if (r < 95) begin
					level = 1'b0;
					hold  = $urandom_range(1, 3);
				end else begin
					level = 1'b0;
					hold  = $urandom_range(5, 40);
				end
			end
			hold--;
			m_axis_tready <= level;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("epoch_seconds_to_calendar verification failed");
			$finish;
		end
	end

	task automatic test_reset_offset();
		send_request(32'd0);
		send_request(32'hFFFF_FFFF);
	endtask

	task automatic test_boundaries();
		set_zone(17'd0);
		send_request(32'd0);
		send_request(32'd59);
		send_request(32'd60);
		send_request(32'd3599);
		send_request(32'd86399);
		send_request(32'd86400);
		send_clamped(month_begin(1971, 1) - 1);
		send_clamped(month_begin(1971, 1));
		send_clamped(month_begin(1972, 3) - SEC_DAY);
		send_clamped(month_begin(1972, 3) - 1);
		send_clamped(month_begin(1972, 3));
		send_clamped(month_begin(1973, 1) - 1);
		// no century rule: 2100 has a Feb 29
		send_clamped(month_begin(2100, 3) - 1);
		send_clamped(month_begin(2100, 3));
		send_request(32'hFFFF_FFFF);
	endtask

	task automatic test_negative_clamp();
		set_zone(17'(ZONE_WEST));
		send_request(32'd0);
		send_request(32'd43199);
		send_request(32'd43200);
		set_zone(17'(ZONE_MIN_RAW));
		send_request(32'd65535);
		send_request(32'd65536);
	endtask

	task automatic test_zone_extremes();
		set_zone(17'(ZONE_MAX_RAW));
		send_request(32'hFFFF_FFFF);
		send_request(32'd0);
	endtask

	task automatic test_random_phase(logic [eds_pkg::ZONE_W-1:0] z, int count);
		int unsigned yr;
		int unsigned mo;
		longint      z_val;
		set_zone(z);
		z_val = zone_now;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 55) begin
				send_request($urandom);
			end else begin
				yr = $urandom_range(1970, 2106);
				mo = $urandom_range(1, 12);
				send_clamped(month_begin(yr, mo) - z_val +
					longint'($urandom_range(0, 400)) - 200);
			end
		end
	endtask

	task automatic test_random();
		test_random_phase(17'(ZONE_EAST), 85);
		test_random_phase(17'(ZONE_WEST), 85);
		test_random_phase(17'd0, 80);
		test_random_phase(17'(ZONE_DEFAULT), 80);
		test_random_phase(17'($urandom_range(0, ZONE_EAST - ZONE_WEST) + ZONE_WEST), 85);
		test_random_phase(17'($urandom_range(0, 131071)), 85);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_offset();
		test_boundaries();
		test_negative_clamp();
		test_zone_extremes();
		test_random();
		drain();
		if (fail_count == 0) begin
			$display("epoch_seconds_to_calendar verification clean");
		end else begin
			$display("epoch_seconds_to_calendar verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
src/eds_pkg.sv
src/eds_divc.sv
src/eds_date.sv
src/epoch_seconds_to_calendar.sv
bench/epoch_seconds_to_calendar_tb.sv
